// ===== rtl/core/pnf_pkg.sv =====
`timescale 1ns / 1ps

package pnf_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = 4;
  localparam int OIDX_W      = 3;
  localparam int PROD_W      = 48;
  localparam int SUM_W       = 24;
  localparam int CELL_DEPTH  = 16;
  localparam int OUT_W       = 20;

  localparam logic signed [SUM_W-1:0] OUT_MAX = 24'sd524287;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -24'sd524288;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic REG_OCTAVE    = 1'b0;
  localparam logic REG_BASE_FREQ = 1'b1;

  // Constants of the quintic fade 6t^5 - 15t^4 + 10t^3 in Q.16.
  localparam logic signed [21:0] FADE_C15 = 22'sd983040;
  localparam logic signed [21:0] FADE_C10 = 22'sd655360;

  // One word handed from cell to cell: the scaled point and the running sum.
  typedef struct packed {
    logic                    vld;
    logic [2:0][PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0] sum;
  } link_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
    8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
    8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
    8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
    8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
    8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
    8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
    8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
    8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
    8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
    8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
    8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
    8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
    8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
    8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
    8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  // Dot product of one of the twelve gradient directions with the offset.
  function automatic logic signed [19:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [19:0] p;
    logic signed [19:0] q;
    p = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      q = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      q = x;
    end else begin
      q = z;
    end
    return (h[0] ? -p : p) + (h[1] ? -q : q);
  endfunction

endpackage

// ===== rtl/core/pnf_point_if.sv =====
`timescale 1ns / 1ps

interface pnf_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;

  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

// ===== rtl/core/pnf_noise_if.sv =====
`timescale 1ns / 1ps

interface pnf_noise_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// ===== rtl/core/pnf_cell.sv =====
`timescale 1ns / 1ps

// One octave of noise, sixteen stages deep. It passes the point on doubled.
module pnf_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [pnf_pkg::OIDX_W-1:0]    oct_index,
  input  logic [pnf_pkg::OCT_W-1:0]     oct_count,
  input  pnf_pkg::link_t                link_in,
  output pnf_pkg::link_t                link_out
);

  logic [pnf_pkg::CELL_DEPTH-1:0]          vld_d;
  logic [2:0][pnf_pkg::PROD_W-1:0]         prod_d [pnf_pkg::CELL_DEPTH];
  logic signed [pnf_pkg::SUM_W-1:0]        sum_d [pnf_pkg::CELL_DEPTH-1];
  logic signed [pnf_pkg::SUM_W-1:0]        sum_out;
  logic [15:0]        f_d [7][3];
  logic [15:0]        fin [3];
  logic [7:0]         cy1, cz1, cz2, pa, pb, a, b;
  logic [7:0]         base [4];
  logic [7:0]         h [8];
  logic signed [21:0] r0 [3];
  logic signed [39:0] m1 [3];
  logic signed [21:0] r1 [3];
  logic signed [39:0] m2 [3];
  logic signed [21:0] r2 [3];
  logic signed [39:0] m3 [3];
  logic signed [21:0] r3 [3];
  logic signed [39:0] m4 [3];
  logic signed [21:0] fade [3];
  logic signed [19:0] g_d [6][8];
  logic signed [20:0] dx [4];
  logic signed [42:0] px [4];
  logic signed [21:0] x [4];
  logic signed [21:0] fv10, fw10, fv11, fw11, fw12, fw13;
  logic signed [21:0] x0c, x2c, y0c;
  logic signed [22:0] dy [2];
  logic signed [44:0] py [2];
  logic signed [21:0] y [2];
  logic signed [22:0] dz;
  logic signed [44:0] pz;
  logic signed [21:0] n;
  logic               active;
  logic signed [pnf_pkg::SUM_W-1:0] contrib;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = link_in.prod[i][39:24];
    end
    for (int m = 0; m < 4; m++) begin
      dx[m] = g_d[4][2*m+1] - g_d[4][2*m];
    end
    dy[0] = x[1] - x[0];
    dy[1] = x[3] - x[2];
    dz = y[1] - y[0];
  end

  assign active  = {1'b0, oct_index} < oct_count;
  assign contrib = active ? (n >>> oct_index) : 24'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
    end else if (en) begin
      vld_d <= {vld_d[pnf_pkg::CELL_DEPTH-2:0], link_in.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The next octave sees the point scaled by twice this octave's factor.
      for (int i = 0; i < 3; i++) begin
        prod_d[0][i] <= {link_in.prod[i][pnf_pkg::PROD_W-2:0], 1'b0};
      end
      for (int k = 1; k < pnf_pkg::CELL_DEPTH; k++) begin
        prod_d[k] <= prod_d[k-1];
      end
      sum_d[0] <= link_in.sum;
      for (int k = 1; k < pnf_pkg::CELL_DEPTH - 1; k++) begin
        sum_d[k] <= sum_d[k-1];
      end

      // Fraction and the fade polynomial, one multiply per stage.
      for (int i = 0; i < 3; i++) begin
        f_d[0][i] <= fin[i];
        r0[i] <= 22'({fin[i], 2'b0}) + 22'({fin[i], 1'b0}) - pnf_pkg::FADE_C15;
        m1[i] <= r0[i] * $signed({2'b0, f_d[0][i]});
        r1[i] <= $signed(m1[i][37:16]) + pnf_pkg::FADE_C10;
        m2[i] <= r1[i] * $signed({2'b0, f_d[2][i]});
        r2[i] <= $signed(m2[i][37:16]);
        m3[i] <= r2[i] * $signed({2'b0, f_d[4][i]});
        r3[i] <= $signed(m3[i][37:16]);
        m4[i] <= r3[i] * $signed({2'b0, f_d[6][i]});
        fade[i] <= $signed(m4[i][37:16]);
      end
      for (int k = 1; k < 7; k++) begin
        f_d[k] <= f_d[k-1];
      end

      // Lattice hash through the permutation table.
      pa  <= pnf_pkg::perm(link_in.prod[0][47:40]);
      pb  <= pnf_pkg::perm(link_in.prod[0][47:40] + 8'd1);
      cy1 <= link_in.prod[1][47:40];
      cz1 <= link_in.prod[2][47:40];
      a   <= pa + cy1;
      b   <= pb + cy1;
      cz2 <= cz1;
      base[0] <= pnf_pkg::perm(a) + cz2;
      base[1] <= pnf_pkg::perm(b) + cz2;
      base[2] <= pnf_pkg::perm(a + 8'd1) + cz2;
      base[3] <= pnf_pkg::perm(b + 8'd1) + cz2;
      for (int c = 0; c < 8; c++) begin
        h[c] <= pnf_pkg::perm(base[c % 4] + 8'(c / 4));
      end

      // Corner gradients; bit 0, 1, 2 of the corner number selects the far
      // side in x, y, z.
      for (int c = 0; c < 8; c++) begin
        g_d[0][c] <= pnf_pkg::grad(h[c][3:0],
          (c % 2 == 1) ? $signed({2'b11, f_d[3][0]}) : $signed({2'b00, f_d[3][0]}),
          ((c / 2) % 2 == 1) ? $signed({2'b11, f_d[3][1]})
                             : $signed({2'b00, f_d[3][1]}),
          (c / 4 == 1) ? $signed({2'b11, f_d[3][2]}) : $signed({2'b00, f_d[3][2]}));
      end
      for (int k = 1; k < 6; k++) begin
        g_d[k] <= g_d[k-1];
      end

      // Trilinear blend: x pairs, then y, then z.
      for (int m = 0; m < 4; m++) begin
        px[m] <= fade[0] * dx[m];
        x[m]  <= g_d[5][2*m] + $signed(px[m][37:16]);
      end
      fv10 <= fade[1];
      fw10 <= fade[2];
      fv11 <= fv10;
      fw11 <= fw10;
      fw12 <= fw11;
      fw13 <= fw12;
      py[0] <= fv11 * dy[0];
      py[1] <= fv11 * dy[1];
      x0c   <= x[0];
      x2c   <= x[2];
      y[0]  <= x0c + $signed(py[0][37:16]);
      y[1]  <= x2c + $signed(py[1][37:16]);
      pz    <= fw13 * dz;
      y0c   <= y[0];
      n     <= y0c + $signed(pz[37:16]);
      sum_out <= sum_d[pnf_pkg::CELL_DEPTH-2] + contrib;
    end
  end

  assign link_out.vld  = vld_d[pnf_pkg::CELL_DEPTH-1];
  assign link_out.prod = prod_d[pnf_pkg::CELL_DEPTH-1];
  assign link_out.sum  = sum_out;

endmodule

// ===== rtl/core/perlin_noise_3d_fbm.sv =====
`timescale 1ns / 1ps

// Fractal sum of 3D improved Perlin noise. A point (x, y, z) in signed Q16.16
// comes in as one word on the point channel; one word with the noise value in
// signed Q4.16, saturated, leaves on the noise channel for every point.
// The datapath is a row of eight octave cells. A scaling stage multiplies the
// point by the base frequency, and each cell adds one octave and hands the
// point, doubled, together with the running sum to its neighbor. Cells past
// the configured octave count only pass the sum along.
// A point passes one scaling stage, sixteen stages in each of the eight cells
// and the output register. A new point is taken in every cycle unless the row
// stalls. When the receiver holds ready low while a word waits, the whole row
// stalls and point.ready falls in the same cycle. Reset clears all valid bits
// and sets octave_count to 3 and base_frequency to 83886. The registers sit on
// the APB port at byte addresses 0 and 4; the user must write them only while
// no point is in flight, and the block itself does not enforce it.
module perlin_noise_3d_fbm (
  input  logic        clk,
  input  logic        rst,
  pnf_point_if.sink   point,
  pnf_noise_if.source noise,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pnf_pkg::OCT_W-1:0] octave_count;
  logic [23:0]               base_frequency;
  logic [pnf_pkg::OCT_W-1:0] oct_n;
  logic                      en;
  logic signed [31:0]        crd [3];
  logic signed [56:0]        prod_full [3];
  pnf_pkg::link_t            scale_link;
  pnf_pkg::link_t            link [pnf_pkg::MAX_OCTAVES];
  logic signed [pnf_pkg::SUM_W-1:0] last_sum;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= 4'd3;
      base_frequency <= 24'd83886;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        pnf_pkg::REG_OCTAVE:    octave_count   <= pwdata[3:0];
        pnf_pkg::REG_BASE_FREQ: base_frequency <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pnf_pkg::REG_OCTAVE:    prdata = {28'd0, octave_count};
      pnf_pkg::REG_BASE_FREQ: prdata = {8'd0, base_frequency};
      default:                prdata = '0;
    endcase
  end

  assign oct_n = (octave_count > 4'(pnf_pkg::MAX_OCTAVES))
               ? 4'(pnf_pkg::MAX_OCTAVES) : octave_count;

  // The row moves whenever the output register is free or being emptied.
  assign en          = !noise.valid || noise.ready;
  assign point.ready = en;

  // Scaling stage: Q16.16 times Q0.24 gives the lattice coordinate in Q.40.
  assign crd[0] = point.x_coord;
  assign crd[1] = point.y_coord;
  assign crd[2] = point.z_coord;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_full[i] = crd[i] * $signed({1'b0, base_frequency});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_link.vld <= 1'b0;
    end else if (en) begin
      scale_link.vld <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        scale_link.prod[i] <= prod_full[i][pnf_pkg::PROD_W-1:0];
      end
      scale_link.sum <= '0;
    end
  end

  for (genvar k = 0; k < pnf_pkg::MAX_OCTAVES; k++) begin : g_cell
    if (k == 0) begin : g_first
      pnf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .oct_index (pnf_pkg::OIDX_W'(k)),
        .oct_count (oct_n),
        .link_in   (scale_link),
        .link_out  (link[k])
      );
    end else begin : g_next
      pnf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .oct_index (pnf_pkg::OIDX_W'(k)),
        .oct_count (oct_n),
        .link_in   (link[k-1]),
        .link_out  (link[k])
      );
    end
  end

  // Output register with saturation to Q4.16.
  assign last_sum = link[pnf_pkg::MAX_OCTAVES-1].sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise.valid <= 1'b0;
    end else if (en) begin
      noise.valid <= link[pnf_pkg::MAX_OCTAVES-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last_sum > pnf_pkg::OUT_MAX) begin
        noise.noise_value <= pnf_pkg::OUT_MAX[pnf_pkg::OUT_W-1:0];
      end else if (last_sum < pnf_pkg::OUT_MIN) begin
        noise.noise_value <= pnf_pkg::OUT_MIN[pnf_pkg::OUT_W-1:0];
      end else begin
        noise.noise_value <= last_sum[pnf_pkg::OUT_W-1:0];
      end
    end
  end

  // An accepted point enters the scaling stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> scale_link.vld)
    else $error("accepted point did not enter the scaling stage");

  // Back-pressure only comes from a word waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !point.ready |-> noise.valid && !noise.ready)
    else $error("input stalled without a waiting result");

  // A word leaving the last cell lands in the output register.
  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    link[pnf_pkg::MAX_OCTAVES-1].vld && en |=> noise.valid)
    else $error("result of the last cell was lost");

endmodule

// ===== tb/sv/pnf_noise_checker.sv =====
`timescale 1ns / 1ps

module pnf_noise_checker (
  input  logic        clk,
  input  logic        rst,
  pnf_point_if        point,
  pnf_noise_if        noise,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  logic [3:0]         octaves;
  logic [23:0]        base_freq;
  logic signed [19:0] noise_expected[$];

  function automatic int perm_at(input int idx);
    logic [7:0] i8;
    i8 = idx[7:0];
    return int'(pnf_pkg::PERM_ROM[i8]);
  endfunction

  function automatic longint fade(input longint t);
    longint r;
    r = 6 * t - 15 * 65536;
    r = ((r * t) >>> 16) + 10 * 65536;
    r = (r * t) >>> 16;
    r = (r * t) >>> 16;
    return (r * t) >>> 16;
  endfunction

  function automatic longint mix(input longint w, input longint a, input longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic longint gdot(input int h, input longint x, input longint y,
                                  input longint z);
    longint p;
    longint q;
    int     hh;
    hh = h & 15;
    p = (hh < 8) ? x : y;
    q = (hh < 4) ? y : ((hh == 12 || hh == 14) ? x : z);
    return ((hh & 1) ? -p : p) + ((hh & 2) ? -q : q);
  endfunction

  function automatic longint octave_noise(input longint c[3], input int o,
                                          input logic [23:0] bf);
    logic [63:0] p;
    int          lattice[3];
    longint      f[3];
    longint      fm[3];
    longint      u, v, w, x0, x1, x2, x3;
    int          a, b, aa, ab, ba, bb;
    for (int i = 0; i < 3; i++) begin
      p = (c[i] * longint'({40'd0, bf})) << o;
      lattice[i] = int'(p[47:40]);
      f[i] = longint'({48'd0, p[39:24]});
      fm[i] = f[i] - 65536;
    end
    u = fade(f[0]);
    v = fade(f[1]);
    w = fade(f[2]);
    a = perm_at(lattice[0]) + lattice[1];
    aa = perm_at(a) + lattice[2];
    ab = perm_at(a + 1) + lattice[2];
    b = perm_at(lattice[0] + 1) + lattice[1];
    ba = perm_at(b) + lattice[2];
    bb = perm_at(b + 1) + lattice[2];
    x0 = mix(u, gdot(perm_at(aa), f[0], f[1], f[2]), gdot(perm_at(ba), fm[0], f[1], f[2]));
    x1 = mix(u, gdot(perm_at(ab), f[0], fm[1], f[2]), gdot(perm_at(bb), fm[0], fm[1], f[2]));
    x2 = mix(u, gdot(perm_at(aa + 1), f[0], f[1], fm[2]),
             gdot(perm_at(ba + 1), fm[0], f[1], fm[2]));
    x3 = mix(u, gdot(perm_at(ab + 1), f[0], fm[1], fm[2]),
             gdot(perm_at(bb + 1), fm[0], fm[1], fm[2]));
    return mix(w, mix(v, x0, x1), mix(v, x2, x3));
  endfunction

  function automatic logic signed [19:0] fbm_noise(input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z,
                                                   input logic [3:0] oct,
                                                   input logic [23:0] bf);
    longint c[3];
    longint sum;
    int     n;
    c[0] = longint'(x);
    c[1] = longint'(y);
    c[2] = longint'(z);
    n = (oct > pnf_pkg::MAX_OCTAVES) ? pnf_pkg::MAX_OCTAVES : int'(oct);
    sum = 0;
    for (int o = 0; o < n; o++) sum += octave_noise(c, o, bf) >>> o;
    if (sum > 524287) sum = 524287;
    if (sum < -524288) sum = -524288;
    return sum[19:0];
  endfunction

  assign pending = noise_expected.size();

  always @(posedge clk) begin
    if (rst) begin
      octaves <= 4'd3;
      base_freq <= 24'd83886;
      fail_count <= 0;
      noise_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == pnf_pkg::REG_BASE_FREQ) base_freq <= pwdata[23:0];
        else octaves <= pwdata[3:0];
      end
      if (point.valid && point.ready)
        noise_expected.push_back(fbm_noise(point.x_coord, point.y_coord, point.z_coord,
                                           octaves, base_freq));
      if (noise.valid && noise.ready) begin
        if (noise_expected.size() == 0) begin
          $error("noise_value: unexpected word, actual %0d", noise.noise_value);
          fail_count <= fail_count + 1;
        end else if (noise_expected[0] !== noise.noise_value) begin
          $error("noise_value: expected %0d, actual %0d", noise_expected[0],
                 noise.noise_value);
          fail_count <= fail_count + 1;
          void'(noise_expected.pop_front());
        end else begin
          void'(noise_expected.pop_front());
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_perlin_noise_3d_fbm.sv =====
`timescale 1ns / 1ps

module tb_perlin_noise_3d_fbm;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count;

  // Percent of cycles in which the sender and the receiver sit idle.
  int          send_idle_pct;
  int          recv_idle_pct;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit          hold_off_req;

  pnf_point_if point ();
  pnf_noise_if noise ();

  perlin_noise_3d_fbm dut (
    .clk    (clk),
    .rst    (rst),
    .point  (point),
    .noise  (noise),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pnf_noise_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .point     (point),
    .noise     (noise),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog ends the run if the block stops moving words.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 600000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: drops ready at random, and on request holds it low so that the
  // octave row fills up and the point channel stalls.
  initial begin
    noise.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        noise.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      noise.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One APB write: a setup phase, then an access phase at whose closing edge
  // the register takes the value.
  task automatic apb_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Offers one point word and returns once the block has taken it. Idle
  // cycles are inserted in front of the word, never while it is on offer.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      point.valid = 1'b0;
      @(negedge clk);
    end
    point.valid = 1'b1;
    point.x_coord = x;
    point.y_coord = y;
    point.z_coord = z;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  // Lets the row drain: every expected word has arrived, then the latency of
  // the pipeline passes so nothing is still in flight.
  task automatic drain;
    @(negedge clk);
    point.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  // Each coordinate is, with equal odds, near the origin where the lattice is
  // dense or random in every bit, so that all coordinate bits toggle.
  task automatic send_random(input int count);
    logic [31:0] c[3];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(1) == 0) c[i] = $urandom();
        else c[i] = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
      end
      send_point(c[0], c[1], c[2]);
    end
  endtask

  initial begin
    logic [31:0] edge_vals[8];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    point.valid = 1'b0;
    point.x_coord = '0;
    point.y_coord = '0;
    point.z_coord = '0;
    hold_off_req = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 58;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words at the reset setting: the origin, the extremes of every
    // coordinate, small negative values where floor differs from truncation,
    // and points just off a lattice corner.
    edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'hFFFE_FFFF};
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8]);
    drain();

    // Full frequency and the largest octave count, then a count beyond the
    // maximum, which the block caps at eight.
    apb_write(pnf_pkg::REG_BASE_FREQ, 32'h00FF_FFFF);
    apb_write(pnf_pkg::REG_OCTAVE, 32'd8);
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[i + 1], edge_vals[i + 2]);
    drain();
    apb_write(pnf_pkg::REG_OCTAVE, 32'd15);
    send_point(32'h1234_5678, 32'h8765_4321, 32'hFFFF_0001);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();

    // Zero octaves gives a zero result, and so does a zero base frequency.
    apb_write(pnf_pkg::REG_OCTAVE, 32'd0);
    send_point(32'h0003_4000, 32'hFFFF_1000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h0000_0001, 32'h4000_0000);
    drain();
    apb_write(pnf_pkg::REG_OCTAVE, 32'd4);
    apb_write(pnf_pkg::REG_BASE_FREQ, 32'd0);
    send_point(32'h0003_4000, 32'hFFFF_1000, 32'h7FFF_FFFF);
    drain();

    // Random phase one: sender idles 31 percent, receiver 58 percent.
    apb_write(pnf_pkg::REG_BASE_FREQ, 32'd1);
    apb_write(pnf_pkg::REG_OCTAVE, 32'd1);
    send_random(150);
    drain();
    apb_write(pnf_pkg::REG_BASE_FREQ, 32'd83886);
    apb_write(pnf_pkg::REG_OCTAVE, 32'd3);
    send_random(300);
    drain();

    // Random phase two: the idle rates swap.
    send_idle_pct = 58;
    recv_idle_pct = 31;
    apb_write(pnf_pkg::REG_BASE_FREQ, 32'h0010_0000);
    apb_write(pnf_pkg::REG_OCTAVE, 32'd8);
    send_random(400);
    drain();

    // Random phase three: no idling at all, with one long hold-off on the
    // receiver while points keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(pnf_pkg::REG_BASE_FREQ, 32'h00FF_FFFF);
    apb_write(pnf_pkg::REG_OCTAVE, 32'd5);
    hold_off_req = 1'b1;
    send_random(480);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
